FILE: rtl/core/cfsp_pkg.sv
// ----------------------------------------------------------------------------
// Class-file structure parser package
// Phase codes, token element codes, per-phase tables and transaction types.
// ----------------------------------------------------------------------------
`default_nettype none
package cfsp_pkg;

   typedef enum logic [4:0] {
      PH_MAGIC, PH_MINOR, PH_MAJOR, PH_PCOUNT, PH_TAG, PH_IDX1, PH_IDX2,
      PH_NUM4, PH_NUM8, PH_ULEN, PH_UBYTE, PH_MHKIND, PH_MHIDX, PH_ACC,
      PH_THIS, PH_SUPER, PH_ICOUNT, PH_IFACE, PH_FCOUNT, PH_MCOUNT,
      PH_CACOUNT, PH_MACC, PH_MNAME, PH_MDESC, PH_MACOUNT, PH_ANAME,
      PH_ALEN, PH_APAY, PH_DONE
   } phase_type;

   localparam logic [4:0] EL_ERROR = 5'd26;
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_TRUNC = 2'd1;
   localparam logic [1:0] ERR_TAG = 2'd2;
   localparam logic [2:0] SEC_HEADER = 3'd0;
   localparam logic [2:0] SEC_POOL = 3'd1;
   localparam logic [2:0] SEC_IFACE = 3'd2;
   localparam logic [2:0] SEC_FIELDS = 3'd3;
   localparam logic [2:0] SEC_METHODS = 3'd4;
   localparam logic [2:0] SEC_CATTR = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  section;
      logic [4:0]  element;
      logic [63:0] value;
      logic [15:0] item_index;
      logic [15:0] attr_index;
      logic [1:0]  error_code;
      logic        complete;
   } rsp_type;

   // field width in bytes
   function automatic logic [3:0] ph_width(input phase_type ph);
      case (ph)
         PH_MAGIC, PH_NUM4, PH_ALEN: ph_width = 4'd4;
         PH_NUM8: ph_width = 4'd8;
         PH_TAG, PH_UBYTE, PH_MHKIND, PH_APAY, PH_DONE: ph_width = 4'd1;
         default: ph_width = 4'd2;
      endcase
   endfunction

   function automatic logic [4:0] ph_elem(input phase_type ph);
      case (ph)
         PH_FCOUNT, PH_MCOUNT, PH_CACOUNT: ph_elem = 5'd18;
         PH_DONE: ph_elem = 5'd0;
         default: ph_elem = (ph > PH_CACOUNT) ? 5'(ph - 5'd2) : 5'(ph);
      endcase
   endfunction

   function automatic logic [2:0] ph_sect(input phase_type ph, input logic [2:0] owner);
      if (ph >= PH_TAG && ph <= PH_MHIDX) ph_sect = SEC_POOL;
      else if (ph == PH_ICOUNT || ph == PH_IFACE) ph_sect = SEC_IFACE;
      else if (ph == PH_FCOUNT) ph_sect = SEC_FIELDS;
      else if (ph == PH_MCOUNT) ph_sect = SEC_METHODS;
      else if (ph == PH_CACOUNT) ph_sect = SEC_CATTR;
      else if (ph >= PH_MACC && ph <= PH_APAY) ph_sect = owner;
      else ph_sect = SEC_HEADER;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cfsp_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload per transaction between a source and a sink.
// ----------------------------------------------------------------------------
`default_nettype none
interface cfsp_req_if;
   logic                 valid;
   logic                 ready;
   cfsp_pkg::req_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cfsp_rsp_if;
   logic                 valid;
   logic                 ready;
   cfsp_pkg::rsp_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/class_file_structure_parser_core.sv
// ----------------------------------------------------------------------------
// Class-file structure parser core
// Assembles big-endian class-file fields byte by byte and emits tokens.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the output register can take a token;
// each byte updates the registered parse state and produces at most one token into
// a single output register. A new byte is taken whenever that register is empty or
// being drained, so the throughput is one byte per clock; its token shows next cycle.
`default_nettype none
module class_file_structure_parser_core (
   input  wire logic      clock,
   input  wire logic      reset,
   cfsp_req_if.sink       req,
   cfsp_rsp_if.source     rsp
);

   cfsp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  bytes_ff, bytes_in;
   logic [63:0] acc_ff, acc_in;
   logic [15:0] slot_ff, slot_in, pcount_ff, pcount_in;
   logic [4:0]  tag_ff, tag_in;
   logic [15:0] icnt_ff, icnt_in, itot_ff, itot_in, acnt_ff, acnt_in, atot_ff, atot_in;
   logic [31:0] prem_ff, prem_in;
   logic        stop_ff, stop_in;
   logic [2:0]  owner_ff, owner_in;
   logic        vld_ff, vld_in;
   cfsp_pkg::rsp_type out_ff, out_in;

   logic take;
   logic [63:0] acc;
   logic finished, done, tagerr, emit;
   logic [7:0] b;
   logic last;
   logic [15:0] v16;
   logic [16:0] nslot;
   logic [15:0] icnt1, acnt1;
   logic [31:0] prem1;

   assign req.ready = !vld_ff || rsp.ready;
   assign take = req.valid && req.ready;
   assign rsp.valid = vld_ff;
   assign rsp.payload = out_ff;
   assign b = req.payload.data_byte;
   assign last = req.payload.last_byte;
   assign acc = {acc_ff[55:0], b};
   assign v16 = acc[15:0];
   assign icnt1 = icnt_ff + 16'd1;
   assign acnt1 = acnt_ff + 16'd1;
   assign prem1 = prem_ff - 32'd1;

   always_comb begin
      phase_in = phase_ff; bytes_in = bytes_ff; acc_in = acc_ff;
      slot_in = slot_ff; pcount_in = pcount_ff; tag_in = tag_ff;
      icnt_in = icnt_ff; itot_in = itot_ff; acnt_in = acnt_ff; atot_in = atot_ff;
      prem_in = prem_ff; stop_in = stop_ff; owner_in = owner_ff;
      done = 1'b0; tagerr = 1'b0; emit = 1'b0; nslot = '0;
      finished = ({1'b0, bytes_ff} + 4'd1) >= cfsp_pkg::ph_width(phase_ff);
      out_in = '0;
      out_in.section = cfsp_pkg::ph_sect(phase_ff, owner_ff);
      out_in.value = acc;
      if (phase_ff >= cfsp_pkg::PH_TAG && phase_ff <= cfsp_pkg::PH_MHIDX)
         out_in.item_index = slot_ff;
      else if (phase_ff == cfsp_pkg::PH_IFACE ||
               (phase_ff >= cfsp_pkg::PH_MACC && phase_ff <= cfsp_pkg::PH_MACOUNT))
         out_in.item_index = icnt_ff;
      else if (phase_ff >= cfsp_pkg::PH_ANAME && phase_ff <= cfsp_pkg::PH_APAY &&
               owner_ff != cfsp_pkg::SEC_CATTR)
         out_in.item_index = icnt_ff;
      if (phase_ff >= cfsp_pkg::PH_ANAME && phase_ff <= cfsp_pkg::PH_APAY)
         out_in.attr_index = acnt_ff;
      out_in.element = cfsp_pkg::ph_elem(phase_ff);

      if (take) begin
         if (stop_ff || phase_ff == cfsp_pkg::PH_DONE) begin
            emit = 1'b0;
         end else if (!finished) begin
            acc_in = acc; bytes_in = bytes_ff + 3'd1;
            if (last) begin
               emit = 1'b1; out_in.element = cfsp_pkg::EL_ERROR;
               out_in.error_code = cfsp_pkg::ERR_TRUNC;
            end
         end else begin
            emit = 1'b1; acc_in = '0; bytes_in = '0;
            case (phase_ff)
               cfsp_pkg::PH_MAGIC: phase_in = cfsp_pkg::PH_MINOR;
               cfsp_pkg::PH_MINOR: phase_in = cfsp_pkg::PH_MAJOR;
               cfsp_pkg::PH_MAJOR: phase_in = cfsp_pkg::PH_PCOUNT;
               cfsp_pkg::PH_PCOUNT: begin
                  pcount_in = v16; slot_in = 16'd1;
                  phase_in = (v16 > 16'd1) ? cfsp_pkg::PH_TAG : cfsp_pkg::PH_ACC;
               end
               cfsp_pkg::PH_TAG: begin
                  tag_in = acc[4:0];
                  case (acc[7:0])
                     8'd1: phase_in = cfsp_pkg::PH_ULEN;
                     8'd3, 8'd4: phase_in = cfsp_pkg::PH_NUM4;
                     8'd5, 8'd6: phase_in = cfsp_pkg::PH_NUM8;
                     8'd7, 8'd8, 8'd16, 8'd19, 8'd20, 8'd9, 8'd10, 8'd11, 8'd12,
                     8'd17, 8'd18: phase_in = cfsp_pkg::PH_IDX1;
                     8'd15: phase_in = cfsp_pkg::PH_MHKIND;
                     default: begin tagerr = 1'b1; stop_in = 1'b1; end
                  endcase
               end
               cfsp_pkg::PH_IDX1: begin
                  if (tag_ff inside {5'd9, 5'd10, 5'd11, 5'd12, 5'd17, 5'd18})
                     phase_in = cfsp_pkg::PH_IDX2;
                  else nslot = {1'b0, slot_ff} + 17'd1;
               end
               cfsp_pkg::PH_IDX2, cfsp_pkg::PH_NUM4, cfsp_pkg::PH_MHIDX:
                  nslot = {1'b0, slot_ff} + 17'd1;
               cfsp_pkg::PH_NUM8: nslot = {1'b0, slot_ff} + 17'd2;
               cfsp_pkg::PH_ULEN: begin
                  prem_in = {16'd0, v16};
                  if (v16 == 16'd0) nslot = {1'b0, slot_ff} + 17'd1;
                  else phase_in = cfsp_pkg::PH_UBYTE;
               end
               cfsp_pkg::PH_UBYTE: begin
                  prem_in = prem1;
                  if (prem1 == 32'd0) nslot = {1'b0, slot_ff} + 17'd1;
               end
               cfsp_pkg::PH_MHKIND: phase_in = cfsp_pkg::PH_MHIDX;
               cfsp_pkg::PH_ACC: phase_in = cfsp_pkg::PH_THIS;
               cfsp_pkg::PH_THIS: phase_in = cfsp_pkg::PH_SUPER;
               cfsp_pkg::PH_SUPER: phase_in = cfsp_pkg::PH_ICOUNT;
               cfsp_pkg::PH_ICOUNT: begin
                  itot_in = v16; icnt_in = '0;
                  phase_in = (v16 != 0) ? cfsp_pkg::PH_IFACE : cfsp_pkg::PH_FCOUNT;
               end
               cfsp_pkg::PH_IFACE: begin
                  icnt_in = icnt1;
                  if (icnt1 >= itot_ff) phase_in = cfsp_pkg::PH_FCOUNT;
               end
               cfsp_pkg::PH_FCOUNT, cfsp_pkg::PH_MCOUNT: begin
                  owner_in = (phase_ff == cfsp_pkg::PH_FCOUNT) ?
                             cfsp_pkg::SEC_FIELDS : cfsp_pkg::SEC_METHODS;
                  itot_in = v16; icnt_in = '0;
                  if (v16 != 0) phase_in = cfsp_pkg::PH_MACC;
                  else phase_in = (phase_ff == cfsp_pkg::PH_FCOUNT) ?
                                  cfsp_pkg::PH_MCOUNT : cfsp_pkg::PH_CACOUNT;
               end
               cfsp_pkg::PH_CACOUNT: begin
                  owner_in = cfsp_pkg::SEC_CATTR; atot_in = v16; acnt_in = '0;
                  if (v16 != 0) phase_in = cfsp_pkg::PH_ANAME;
                  else begin phase_in = cfsp_pkg::PH_DONE; done = 1'b1; end
               end
               cfsp_pkg::PH_MACC: phase_in = cfsp_pkg::PH_MNAME;
               cfsp_pkg::PH_MNAME: phase_in = cfsp_pkg::PH_MDESC;
               cfsp_pkg::PH_MDESC: phase_in = cfsp_pkg::PH_MACOUNT;
               cfsp_pkg::PH_MACOUNT: begin
                  atot_in = v16; acnt_in = '0;
                  if (v16 != 0) phase_in = cfsp_pkg::PH_ANAME;
                  else begin
                     icnt_in = icnt1;
                     if (icnt1 < itot_ff) phase_in = cfsp_pkg::PH_MACC;
                     else phase_in = (owner_ff == cfsp_pkg::SEC_FIELDS) ?
                                     cfsp_pkg::PH_MCOUNT : cfsp_pkg::PH_CACOUNT;
                  end
               end
               cfsp_pkg::PH_ANAME: phase_in = cfsp_pkg::PH_ALEN;
               cfsp_pkg::PH_ALEN, cfsp_pkg::PH_APAY: begin
                  prem_in = (phase_ff == cfsp_pkg::PH_ALEN) ? acc[31:0] : prem1;
                  if (prem_in == 32'd0) begin
                     acnt_in = acnt1;
                     if (acnt1 < atot_ff) phase_in = cfsp_pkg::PH_ANAME;
                     else if (owner_ff == cfsp_pkg::SEC_CATTR) begin
                        phase_in = cfsp_pkg::PH_DONE; done = 1'b1;
                     end else begin
                        icnt_in = icnt1;
                        if (icnt1 < itot_ff) phase_in = cfsp_pkg::PH_MACC;
                        else phase_in = (owner_ff == cfsp_pkg::SEC_FIELDS) ?
                                        cfsp_pkg::PH_MCOUNT : cfsp_pkg::PH_CACOUNT;
                     end
                  end else if (phase_ff == cfsp_pkg::PH_ALEN)
                     phase_in = cfsp_pkg::PH_APAY;
               end
               default: ;
            endcase
            if (nslot != '0) begin
               if (nslot < {1'b0, pcount_ff}) begin
                  slot_in = nslot[15:0]; phase_in = cfsp_pkg::PH_TAG;
               end else phase_in = cfsp_pkg::PH_ACC;
            end
            if (tagerr) begin
               out_in.element = cfsp_pkg::EL_ERROR; out_in.error_code = cfsp_pkg::ERR_TAG;
            end else if (last && !done) begin
               out_in.element = cfsp_pkg::EL_ERROR; out_in.error_code = cfsp_pkg::ERR_TRUNC;
            end else out_in.complete = done;
         end
         if (last) begin
            phase_in = cfsp_pkg::PH_MAGIC; bytes_in = '0; acc_in = '0;
            slot_in = 16'd1; pcount_in = '0; tag_in = '0; icnt_in = '0; itot_in = '0;
            acnt_in = '0; atot_in = '0; prem_in = '0; stop_in = 1'b0; owner_in = '0;
         end
      end
      vld_in = take ? emit : (vld_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cfsp_pkg::PH_MAGIC; bytes_ff <= '0; acc_ff <= '0;
         slot_ff <= 16'd1; pcount_ff <= '0; tag_ff <= '0; icnt_ff <= '0;
         itot_ff <= '0; acnt_ff <= '0; atot_ff <= '0; prem_ff <= '0;
         stop_ff <= 1'b0; owner_ff <= '0; vld_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; bytes_ff <= bytes_in; acc_ff <= acc_in;
         slot_ff <= slot_in; pcount_ff <= pcount_in; tag_ff <= tag_in;
         icnt_ff <= icnt_in; itot_ff <= itot_in; acnt_ff <= acnt_in;
         atot_ff <= atot_in; prem_ff <= prem_in; stop_ff <= stop_in;
         owner_ff <= owner_in; vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) out_ff <= out_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/cfsp_checker.sv
// ----------------------------------------------------------------------------
// Class-file structure parser port checker
// Watches the top-level channels for token-level consistency.
// ----------------------------------------------------------------------------
`default_nettype none
module cfsp_checker (
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      req_valid,
   input wire logic      req_ready,
   input wire logic      rsp_valid,
   input wire logic      rsp_ready,
   input wire cfsp_pkg::rsp_type rsp_payload
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");
   a_err_elem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error_code != cfsp_pkg::ERR_NONE |->
      rsp_payload.element == cfsp_pkg::EL_ERROR && !rsp_payload.complete)
      else $error("error token malformed");
   a_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.complete |->
      rsp_payload.section == cfsp_pkg::SEC_CATTR)
      else $error("complete outside class attributes");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");
   a_new: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("response without a request");
endmodule

bind class_file_structure_parser_core cfsp_checker u_cfsp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Class-file structure parser testbench
// Streams well-formed class files with random content, plus truncated,
// corrupted and noisy streams, into the parser. An in-bench token predictor
// and a scoreboard check every token in order, under random back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

class token_scoreboard;
   cfsp_pkg::rsp_type pending[$];
   int unsigned mismatches;

   function void note_token(cfsp_pkg::rsp_type t);
      pending.insert(pending.size(), t);
   endfunction

   function void check_token(cfsp_pkg::rsp_type got);
      cfsp_pkg::rsp_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected token: sec %0d el %0d val %h", got.section, got.element,
                     got.value);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"token mismatch: exp sec %0d el %0d val %h item %0d attr %0d ",
                      "err %0d cpl %0d / got sec %0d el %0d val %h item %0d attr %0d ",
                      "err %0d cpl %0d"},
                     want.section, want.element, want.value, want.item_index,
                     want.attr_index, want.error_code, want.complete, got.section,
                     got.element, got.value, got.item_index, got.attr_index,
                     got.error_code, got.complete);
      end
   endfunction
endclass

module tb_top;
   import cfsp_pkg::*;

   logic clock;
   logic reset;
   cfsp_req_if req ();
   cfsp_rsp_if rsp ();

   class_file_structure_parser_core dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   token_scoreboard tokens = new();

   // parser state mirror
   phase_type   ph;
   logic [2:0]  nbytes;
   logic [63:0] acc_q;
   logic [15:0] slot, pcount, icnt, itot, acnt, atot;
   logic [4:0]  tag;
   logic [31:0] remain;
   logic        halted;
   logic [2:0]  owner;
   logic        fin, tagbad;

   int send_gap, recv_gap;
   longint cycles = 0;
   byte unsigned file_q[$];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic void parser_restart();
      ph = PH_MAGIC; nbytes = 0; acc_q = 0; slot = 1; pcount = 0; tag = 0;
      icnt = 0; itot = 0; acnt = 0; atot = 0; remain = 0; halted = 0; owner = 0;
   endfunction

   function automatic void to_next_entry(logic [16:0] stp);
      logic [16:0] s;
      s = slot + stp;
      if (s < {1'b0, pcount}) begin
         slot = s[15:0]; ph = PH_TAG;
      end else ph = PH_ACC;
   endfunction

   function automatic void close_table();
      ph = (owner == SEC_FIELDS) ? PH_MCOUNT : PH_CACOUNT;
   endfunction

   function automatic void close_member();
      icnt++;
      if (icnt < itot) ph = PH_MACC; else close_table();
   endfunction

   function automatic void close_attr();
      acnt++;
      if (acnt < atot) ph = PH_ANAME;
      else if (owner == SEC_CATTR) begin
         ph = PH_DONE; fin = 1;
      end else close_member();
   endfunction

   function automatic void advance_phase(logic [63:0] v);
      logic [15:0] v16;
      v16 = v[15:0];
      case (ph)
         PH_MAGIC: ph = PH_MINOR;
         PH_MINOR: ph = PH_MAJOR;
         PH_MAJOR: ph = PH_PCOUNT;
         PH_PCOUNT: begin
            pcount = v16; slot = 1;
            ph = (pcount > 1) ? PH_TAG : PH_ACC;
         end
         PH_TAG: begin
            tag = v[4:0];
            case (v)
               1: ph = PH_ULEN;
               3, 4: ph = PH_NUM4;
               5, 6: ph = PH_NUM8;
               7, 8, 9, 10, 11, 12, 16, 17, 18, 19, 20: ph = PH_IDX1;
               15: ph = PH_MHKIND;
               default: begin
                  tagbad = 1; halted = 1;
               end
            endcase
         end
         PH_IDX1: begin
            if (tag inside {9, 10, 11, 12, 17, 18}) ph = PH_IDX2;
            else to_next_entry(1);
         end
         PH_IDX2, PH_NUM4, PH_MHIDX: to_next_entry(1);
         PH_NUM8: to_next_entry(2);
         PH_ULEN: begin
            remain = v16;
            if (remain == 0) to_next_entry(1); else ph = PH_UBYTE;
         end
         PH_UBYTE: begin
            remain--;
            if (remain == 0) to_next_entry(1);
         end
         PH_MHKIND: ph = PH_MHIDX;
         PH_ACC: ph = PH_THIS;
         PH_THIS: ph = PH_SUPER;
         PH_SUPER: ph = PH_ICOUNT;
         PH_ICOUNT: begin
            itot = v16; icnt = 0;
            ph = (v16 != 0) ? PH_IFACE : PH_FCOUNT;
         end
         PH_IFACE: begin
            icnt++;
            if (icnt >= itot) ph = PH_FCOUNT;
         end
         PH_FCOUNT, PH_MCOUNT: begin
            owner = (ph == PH_FCOUNT) ? SEC_FIELDS : SEC_METHODS;
            itot = v16; icnt = 0;
            if (v16 != 0) ph = PH_MACC; else close_table();
         end
         PH_CACOUNT: begin
            owner = SEC_CATTR; atot = v16; acnt = 0;
            if (v16 != 0) ph = PH_ANAME;
            else begin
               ph = PH_DONE; fin = 1;
            end
         end
         PH_MACC: ph = PH_MNAME;
         PH_MNAME: ph = PH_MDESC;
         PH_MDESC: ph = PH_MACOUNT;
         PH_MACOUNT: begin
            atot = v16; acnt = 0;
            if (v16 != 0) ph = PH_ANAME; else close_member();
         end
         PH_ANAME: ph = PH_ALEN;
         PH_ALEN: begin
            remain = v[31:0];
            if (remain == 0) close_attr(); else ph = PH_APAY;
         end
         PH_APAY: begin
            remain--;
            if (remain == 0) close_attr();
         end
         default: ;
      endcase
   endfunction

   // predicts the token (if any) for one accepted byte
   function automatic void predict_token(logic [7:0] b, logic lst);
      rsp_type t;
      phase_type p;
      logic [3:0] w;
      logic [63:0] a;
      if (halted || ph == PH_DONE) begin
         if (lst) parser_restart();
         return;
      end
      p = ph;
      w = (p == PH_MAGIC || p == PH_NUM4 || p == PH_ALEN) ? 4 : (p == PH_NUM8) ? 8 :
          (p inside {PH_TAG, PH_UBYTE, PH_MHKIND, PH_APAY}) ? 1 : 2;
      t = '0;
      if (p >= PH_TAG && p <= PH_MHIDX) t.section = SEC_POOL;
      else if (p == PH_ICOUNT || p == PH_IFACE) t.section = SEC_IFACE;
      else if (p == PH_FCOUNT) t.section = SEC_FIELDS;
      else if (p == PH_MCOUNT) t.section = SEC_METHODS;
      else if (p == PH_CACOUNT) t.section = SEC_CATTR;
      else if (p >= PH_MACC) t.section = owner;
      else t.section = SEC_HEADER;
      if (p inside {PH_FCOUNT, PH_MCOUNT, PH_CACOUNT}) t.element = 18;
      else if (p > PH_CACOUNT) t.element = 5'(p - 2);
      else t.element = p;
      if (p >= PH_TAG && p <= PH_MHIDX) t.item_index = slot;
      else if (p == PH_IFACE || (p >= PH_MACC && p <= PH_MACOUNT)) t.item_index = icnt;
      else if (p >= PH_ANAME && owner != SEC_CATTR) t.item_index = icnt;
      if (p >= PH_ANAME) t.attr_index = acnt;
      a = {acc_q[55:0], b};
      t.value = a;
      if (nbytes + 1 < w) begin
         acc_q = a; nbytes++;
         if (!lst) return;
         t.element = EL_ERROR; t.error_code = ERR_TRUNC;
         parser_restart();
         tokens.note_token(t);
         return;
      end
      acc_q = 0; nbytes = 0; fin = 0; tagbad = 0;
      advance_phase(a);
      if (tagbad) begin
         t.element = EL_ERROR; t.error_code = ERR_TAG;
      end else if (lst && !fin) begin
         t.element = EL_ERROR; t.error_code = ERR_TRUNC;
      end else t.complete = fin;
      if (lst) parser_restart();
      tokens.note_token(t);
   endfunction

   // ---------------- file construction ----------------
   function automatic void put_n(logic [63:0] v, int n);
      for (int i = n - 1; i >= 0; i--) file_q.insert(file_q.size(), v[8*i +: 8]);
   endfunction

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic void put_attrs(int n, int maxlen);
      int len;
      put_n(n, 2);
      for (int i = 0; i < n; i++) begin
         len = $urandom_range(0, maxlen);
         put_n($urandom, 2); put_n(len, 4);
         for (int k = 0; k < len; k++) file_q.insert(file_q.size(), 8'($urandom));
      end
   endfunction

   function automatic void build_class(int pool_n, int nif, int nf, int nm, int nca,
                                       bit bad_tag);
      int tags[$];
      int s, len, tg;
      int t_opts[] = '{1, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 15, 16, 17, 18, 19, 20};
      file_q.delete();
      put_n($urandom, 4); put_n($urandom, 2); put_n($urandom, 2);
      put_n(pool_n, 2);
      s = 1;
      while (s < pool_n) begin
         tg = t_opts[$urandom_range(0, t_opts.size() - 1)];
         if (bad_tag && $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1)) tg = $urandom_range(21, 255);
            else if ($urandom_range(0, 2) == 0) tg = 0;
            else tg = $urandom_range(0, 1) ? 2 : 13 + $urandom_range(0, 1);
         end
         file_q.insert(file_q.size(), 8'(tg));
         case (tg)
            1: begin
               len = $urandom_range(0, 5); put_n(len, 2);
               for (int k = 0; k < len; k++) file_q.insert(file_q.size(), 8'($urandom));
            end
            3, 4: put_n($urandom, 4);
            5, 6: begin put_n(rnd64(), 8); s++; end
            9, 10, 11, 12, 17, 18: begin put_n($urandom, 2); put_n($urandom, 2); end
            7, 8, 16, 19, 20: put_n($urandom, 2);
            15: begin file_q.insert(file_q.size(), 8'($urandom)); put_n($urandom, 2); end
            default: ;
         endcase
         s++;
      end
      put_n($urandom, 2); put_n($urandom, 2); put_n($urandom, 2);
      put_n(nif, 2);
      for (int i = 0; i < nif; i++) put_n($urandom, 2);
      put_n(nf, 2);
      for (int i = 0; i < nf; i++) begin
         put_n($urandom, 6); put_attrs($urandom_range(0, 2), 4);
      end
      put_n(nm, 2);
      for (int i = 0; i < nm; i++) begin
         put_n($urandom, 6); put_attrs($urandom_range(0, 2), 4);
      end
      put_attrs(nca, 6);
   endfunction

   // ---------------- drivers ----------------
   task automatic send_byte(logic [7:0] b, logic lst);
      while (($urandom_range(0, 99)) < send_gap) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= '{data_byte: b, last_byte: lst};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_token(b, lst);
      @(negedge clock);
   endtask

   task automatic send_file(int cut, bit trailing);
      int n;
      n = (cut > 0 && cut < file_q.size()) ? cut : file_q.size();
      for (int i = 0; i < n; i++)
         send_byte(file_q[i], (i == n - 1) && !trailing);
      if (trailing) begin
         for (int i = 0; i < 3; i++) send_byte($urandom, 1'b0);
         send_byte($urandom, 1'b1);
      end
   endtask

   task automatic random_file(bit allow_bad);
      int kind;
      kind = $urandom_range(0, 9);
      build_class($urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 2),
                  $urandom_range(0, 2), $urandom_range(0, 3), allow_bad && kind == 0);
      if (kind == 1) send_file($urandom_range(1, file_q.size()), 0);
      else if (kind == 2) send_file(0, 1);
      else if (kind == 3) begin
         file_q.delete();
         for (int i = 0; i < $urandom_range(1, 30); i++)
            file_q.insert(file_q.size(), 8'($urandom));
         send_file(0, 0);
      end else send_file(0, 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) tokens.check_token(rsp.payload);
   end

   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(0, 99) >= recv_gap);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.payload = '0;
      send_gap = 0; recv_gap = 0;
      parser_restart();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, random tags, empty parts, truncation, tag error
      build_class(0, 0, 0, 0, 0, 0); send_file(0, 0);
      file_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h02,
                 8'h06, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_file(0, 0);
      build_class(20, 2, 1, 1, 1, 0); send_file(0, 0);
      build_class(6, 1, 1, 1, 2, 1); send_file(0, 0);
      build_class(3, 0, 0, 0, 1, 0); send_file(5, 0);
      build_class(2, 0, 0, 0, 0, 0); send_file(0, 1);
      for (int ph_i = 0; ph_i < 3; ph_i++) begin
         send_gap = (ph_i == 0) ? 8 : (ph_i == 1) ? 59 : 0;
         recv_gap = (ph_i == 0) ? 59 : (ph_i == 1) ? 8 : 0;
         for (int f = 0; f < 4; f++) random_file(1);
      end
      req.valid <= 1'b0;
      while (tokens.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tokens.mismatches == 0 && tokens.pending.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

`default_nettype wire
